// ===== rtl/apa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package apa_pkg;
    localparam int POOL_DEPTH = 256;
    localparam int CNT_W = 9;
    localparam logic [CNT_W-1:0] COUNT_CAP = 9'd256;

    localparam logic [2:0] LS_FREE      = 3'd0;
    localparam logic [2:0] LS_ACTIVE    = 3'd1;
    localparam logic [2:0] LS_EXPIRED   = 3'd2;
    localparam logic [2:0] LS_RELEASED  = 3'd3;
    localparam logic [2:0] LS_ABANDONED = 3'd4;
    localparam logic [2:0] LS_RESERVED  = 3'd5;
    localparam logic [2:0] LS_BACKUP    = 3'd6;
    localparam logic [2:0] LS_UNDEF     = 3'd7;

    typedef enum logic [2:0] {
        ST_AVAIL = 3'd0,
        ST_ALLOC = 3'd1,
        ST_RESV  = 3'd2,
        ST_EXCL  = 3'd3,
        ST_CONF  = 3'd4,
        ST_NONE  = 3'd7
    } entry_st_t;

    typedef enum logic [2:0] {
        OP_INIT    = 3'd0,
        OP_STATIC  = 3'd1,
        OP_ALLOC   = 3'd2,
        OP_RESERVE = 3'd3,
        OP_RELEASE = 3'd4,
        OP_CONFL   = 3'd5,
        OP_SYNC    = 3'd6,
        OP_BAD     = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        RS_OK      = 2'd0,
        RS_NOTPOOL = 2'd1,
        RS_REFUSED = 2'd2,
        RS_NOADDR  = 2'd3
    } rstat_t;

    typedef enum logic [2:0] {
        REG_START = 3'd0,
        REG_COUNT = 3'd1,
        REG_NET   = 3'd2,
        REG_MASK  = 3'd3,
        REG_GW    = 3'd4
    } reg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_SCAN_RD,
        S_SCAN,
        S_REQ_RD,
        S_REQ,
        S_ONE_RD,
        S_ONE,
        S_WRITE,
        S_DONE
    } fsm_t;

    localparam int ENTRY_W = 3 + 48 + 32 + 32;

    function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] c);
        return (c < COUNT_CAP) ? c + 1'b1 : c;
    endfunction

    function automatic logic [CNT_W-1:0] cnt_dec(input logic [CNT_W-1:0] c);
        return (c != '0) ? c - 1'b1 : c;
    endfunction

    function automatic entry_st_t lease_to_state(input logic [2:0] ls);
        case (ls)
            LS_ACTIVE, LS_BACKUP:             return ST_ALLOC;
            LS_RESERVED:                      return ST_RESV;
            LS_ABANDONED:                     return ST_CONF;
            LS_FREE, LS_EXPIRED, LS_RELEASED: return ST_AVAIL;
            default:                          return ST_NONE;
        endcase
    endfunction
endpackage
`default_nettype wire

// ===== rtl/apa_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module apa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/address_pool_allocator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Init writes each of the pool-size entries in turn; allocate scans the table up to three
// times, one entry a cycle; the other ops read one entry and may write it back.
// One word in flight at a time; the next word is taken the cycle after the result is
// accepted, so the table scan sets the rate.
// Reset clears counters, configuration registers and control; table contents are undefined until init.
module address_pool_allocator_unit #(
    parameter int POOL_DEPTH = apa_pkg::POOL_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  op,
    input  wire logic [47:0] client_mac,
    input  wire logic [31:0] address,
    input  wire logic [2:0]  lease_status,
    input  wire logic [31:0] lease_ident,
    input  wire logic [31:0] lease_begin,
    input  wire logic [31:0] lease_finish,
    input  wire logic [31:0] time_now,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [31:0]      granted_address,
    output logic [8:0]       free_count,
    output logic [8:0]       used_count
);
    localparam int AW = $clog2(POOL_DEPTH);
    localparam int EW = apa_pkg::ENTRY_W;

    logic [31:0] start_reg, net_reg, mask_reg, gw_reg;
    logic [8:0]  rcount_reg;
    logic [AW:0] psize;

    apa_pkg::fsm_t state_reg, state_next;
    logic [2:0]  op_reg;
    logic [47:0] mac_reg;
    logic [31:0] addr_reg, lid_reg, lbeg_reg, lfin_reg, now_reg;
    logic [2:0]  lstat_reg;
    logic [AW:0] idx_reg, idx_next;
    logic [1:0]  pass_reg, pass_next;
    logic [8:0]  avail_reg, avail_next, alloc_reg, alloc_next;
    logic [1:0]  status_reg, status_next;
    logic [31:0] grant_reg, grant_next;
    logic        ov_reg, ov_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rdata;
    logic [EW-1:0] wentry_reg, wentry_next;
    logic [AW-1:0] wslot_reg, wslot_next;

    apa_pkg::entry_st_t r_st;
    logic [47:0] r_mac;
    logic [31:0] r_time, r_lease;
    logic [31:0] off, slot_addr, bcast;
    logic        in_pool, excl;

    assign psize = (32'(rcount_reg) > 32'(POOL_DEPTH)) ? (AW+1)'(POOL_DEPTH)
                                                      : (AW+1)'(rcount_reg);
    assign off = addr_reg - start_reg;
    assign in_pool = off < 32'(psize);
    assign slot_addr = start_reg + 32'(idx_reg);
    assign bcast = net_reg | ~mask_reg;
    assign excl = (((slot_addr & mask_reg) == net_reg) && slot_addr == net_reg)
                  || slot_addr == bcast || slot_addr == gw_reg;
    assign r_st = apa_pkg::entry_st_t'(rdata[EW-1 -: 3]);
    assign r_mac = rdata[111:64];
    assign r_time = rdata[63:32];
    assign r_lease = rdata[31:0];

    apa_ram #(.WIDTH(EW), .DEPTH(POOL_DEPTH)) u_table (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg  <= '0;
            rcount_reg <= '0;
            net_reg    <= '0;
            mask_reg   <= '0;
            gw_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (apa_pkg::reg_idx_t'(cfg_index))
                apa_pkg::REG_START: start_reg  <= cfg_data;
                apa_pkg::REG_COUNT: rcount_reg <= cfg_data[8:0];
                apa_pkg::REG_NET:   net_reg    <= cfg_data;
                apa_pkg::REG_MASK:  mask_reg   <= cfg_data;
                apa_pkg::REG_GW:    gw_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= apa_pkg::S_IDLE;
            idx_reg   <= '0;
            pass_reg  <= '0;
            avail_reg <= '0;
            alloc_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            pass_reg  <= pass_next;
            avail_reg <= avail_next;
            alloc_reg <= alloc_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        grant_reg  <= grant_next;
        wentry_reg <= wentry_next;
        wslot_reg  <= wslot_next;
        if (in_valid && in_ready)
        begin
            op_reg    <= op;
            mac_reg   <= client_mac;
            addr_reg  <= address;
            lstat_reg <= lease_status;
            lid_reg   <= lease_ident;
            lbeg_reg  <= lease_begin;
            lfin_reg  <= lease_finish;
            now_reg   <= time_now;
        end
    end

    assign in_ready = (state_reg == apa_pkg::S_IDLE) && !ov_reg;

    always_comb
    begin
        apa_pkg::entry_st_t nw;
        logic [2:0] ls;
        state_next  = state_reg;
        idx_next    = idx_reg;
        pass_next   = pass_reg;
        avail_next  = avail_reg;
        alloc_next  = alloc_reg;
        status_next = status_reg;
        grant_next  = grant_reg;
        ov_next     = ov_reg;
        wentry_next = wentry_reg;
        wslot_next  = wslot_reg;
        we    = 1'b0;
        waddr = idx_reg[AW-1:0];
        wdata = '0;
        raddr = idx_reg[AW-1:0];
        nw    = apa_pkg::ST_NONE;
        ls    = lstat_reg;
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        unique case (state_reg)
            apa_pkg::S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    status_next = apa_pkg::RS_OK;
                    grant_next  = '0;
                    idx_next    = '0;
                    pass_next   = '0;
                    unique case (apa_pkg::op_t'(op))
                        apa_pkg::OP_INIT:
                        begin
                            avail_next = '0;
                            alloc_next = '0;
                            state_next = apa_pkg::S_INIT;
                        end
                        apa_pkg::OP_ALLOC: state_next = apa_pkg::S_SCAN_RD;
                        apa_pkg::OP_BAD:
                        begin
                            status_next = apa_pkg::RS_REFUSED;
                            state_next  = apa_pkg::S_DONE;
                        end
                        default: state_next = apa_pkg::S_ONE_RD;
                    endcase
                end
            end
            apa_pkg::S_INIT:
            begin
                if (idx_reg >= psize)
                begin
                    state_next = apa_pkg::S_DONE;
                end
                else
                begin
                    we    = 1'b1;
                    wdata = {excl ? apa_pkg::ST_EXCL : apa_pkg::ST_AVAIL, 112'd0};
                    if (!excl)
                    begin
                        avail_next = apa_pkg::cnt_inc(avail_reg);
                    end
                    idx_next = idx_reg + 1'b1;
                end
            end
            apa_pkg::S_SCAN_RD:
            begin
                idx_next   = '0;
                state_next = apa_pkg::S_SCAN;
                if (psize == '0)
                begin
                    state_next = (pass_reg == 2'd2) ? apa_pkg::S_DONE : apa_pkg::S_SCAN_RD;
                    if (pass_reg == 2'd2)
                    begin
                        status_next = apa_pkg::RS_NOADDR;
                    end
                    else if (pass_reg == 2'd1)
                    begin
                        state_next = apa_pkg::S_REQ_RD;
                    end
                    pass_next = pass_reg + 1'b1;
                end
                else
                begin
                    idx_next = (AW+1)'(1);
                end
                raddr = '0;
            end
            apa_pkg::S_SCAN:
            begin
                logic hit;
                logic [AW:0] cur;
                cur = idx_reg - 1'b1;
                unique case (pass_reg)
                    2'd0:    hit = (r_st == apa_pkg::ST_RESV) && (r_mac == mac_reg);
                    2'd1:    hit = (r_st == apa_pkg::ST_ALLOC) && (r_mac == mac_reg);
                    default: hit = (r_st == apa_pkg::ST_AVAIL);
                endcase
                if (hit)
                begin
                    grant_next = start_reg + 32'(cur);
                    if (pass_reg == 2'd2)
                    begin
                        wslot_next  = cur[AW-1:0];
                        wentry_next = {apa_pkg::ST_ALLOC, mac_reg, now_reg, r_lease};
                        avail_next  = apa_pkg::cnt_dec(avail_reg);
                        alloc_next  = apa_pkg::cnt_inc(alloc_reg);
                        state_next  = apa_pkg::S_WRITE;
                    end
                    else
                    begin
                        state_next = apa_pkg::S_DONE;
                    end
                end
                else if (idx_reg >= psize)
                begin
                    idx_next  = '0;
                    pass_next = pass_reg + 1'b1;
                    if (pass_reg == 2'd0)
                    begin
                        state_next = apa_pkg::S_SCAN_RD;
                    end
                    else if (pass_reg == 2'd1)
                    begin
                        state_next = apa_pkg::S_REQ_RD;
                    end
                    else
                    begin
                        status_next = apa_pkg::RS_NOADDR;
                        state_next  = apa_pkg::S_DONE;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            apa_pkg::S_REQ_RD:
            begin
                raddr = off[AW-1:0];
                pass_next = 2'd2;
                if (addr_reg != '0 && in_pool)
                begin
                    state_next = apa_pkg::S_REQ;
                end
                else
                begin
                    state_next = apa_pkg::S_SCAN_RD;
                end
            end
            apa_pkg::S_REQ:
            begin
                if (r_st == apa_pkg::ST_AVAIL)
                begin
                    grant_next  = addr_reg;
                    wslot_next  = off[AW-1:0];
                    wentry_next = {apa_pkg::ST_ALLOC, mac_reg, now_reg, r_lease};
                    avail_next  = apa_pkg::cnt_dec(avail_reg);
                    alloc_next  = apa_pkg::cnt_inc(alloc_reg);
                    state_next  = apa_pkg::S_WRITE;
                end
                else
                begin
                    state_next = apa_pkg::S_SCAN_RD;
                end
            end
            apa_pkg::S_ONE_RD:
            begin
                raddr = off[AW-1:0];
                if (in_pool)
                begin
                    state_next = apa_pkg::S_ONE;
                end
                else
                begin
                    status_next = apa_pkg::RS_NOTPOOL;
                    state_next  = apa_pkg::S_DONE;
                end
            end
            apa_pkg::S_ONE:
            begin
                wslot_next  = off[AW-1:0];
                wentry_next = rdata;
                state_next  = apa_pkg::S_DONE;
                unique case (apa_pkg::op_t'(op_reg))
                    apa_pkg::OP_STATIC:
                    begin
                        wentry_next = {apa_pkg::ST_RESV, mac_reg, r_time, r_lease};
                        avail_next  = apa_pkg::cnt_dec(avail_reg);
                        state_next  = apa_pkg::S_WRITE;
                    end
                    apa_pkg::OP_RESERVE:
                    begin
                        if ((r_st == apa_pkg::ST_ALLOC && r_mac != mac_reg)
                            || r_st == apa_pkg::ST_RESV || r_st == apa_pkg::ST_EXCL)
                        begin
                            status_next = apa_pkg::RS_REFUSED;
                        end
                        else if (r_st == apa_pkg::ST_ALLOC)
                        begin
                            wentry_next = {r_st, r_mac, now_reg, r_lease};
                            state_next  = apa_pkg::S_WRITE;
                        end
                        else
                        begin
                            if (r_st == apa_pkg::ST_AVAIL)
                            begin
                                avail_next = apa_pkg::cnt_dec(avail_reg);
                                alloc_next = apa_pkg::cnt_inc(alloc_reg);
                            end
                            else if (r_st == apa_pkg::ST_CONF)
                            begin
                                alloc_next = apa_pkg::cnt_inc(alloc_reg);
                            end
                            wentry_next = {apa_pkg::ST_ALLOC, mac_reg, now_reg, r_lease};
                            state_next  = apa_pkg::S_WRITE;
                        end
                    end
                    apa_pkg::OP_RELEASE:
                    begin
                        if (r_st == apa_pkg::ST_ALLOC)
                        begin
                            wentry_next = {apa_pkg::ST_AVAIL, 48'd0, r_time, r_lease};
                            alloc_next  = apa_pkg::cnt_dec(alloc_reg);
                            avail_next  = apa_pkg::cnt_inc(avail_reg);
                            state_next  = apa_pkg::S_WRITE;
                        end
                    end
                    apa_pkg::OP_CONFL:
                    begin
                        if (r_st == apa_pkg::ST_AVAIL)
                        begin
                            avail_next = apa_pkg::cnt_dec(avail_reg);
                        end
                        else if (r_st == apa_pkg::ST_ALLOC)
                        begin
                            alloc_next = apa_pkg::cnt_dec(alloc_reg);
                        end
                        wentry_next = {apa_pkg::ST_CONF, r_mac, r_time, r_lease};
                        state_next  = apa_pkg::S_WRITE;
                    end
                    apa_pkg::OP_SYNC:
                    begin
                        if (r_st != apa_pkg::ST_RESV)
                        begin
                            if (lstat_reg == apa_pkg::LS_ACTIVE && lfin_reg < now_reg)
                            begin
                                ls = apa_pkg::LS_EXPIRED;
                            end
                            nw = apa_pkg::lease_to_state(ls);
                            if (nw == apa_pkg::ST_NONE)
                            begin
                                status_next = apa_pkg::RS_REFUSED;
                            end
                            else
                            begin
                                logic [8:0] av, al;
                                av = avail_reg;
                                al = alloc_reg;
                                if (r_st == apa_pkg::ST_AVAIL)
                                begin
                                    av = apa_pkg::cnt_dec(av);
                                end
                                else if (r_st == apa_pkg::ST_ALLOC)
                                begin
                                    al = apa_pkg::cnt_dec(al);
                                end
                                if (nw == apa_pkg::ST_AVAIL)
                                begin
                                    av = apa_pkg::cnt_inc(av);
                                end
                                else if (nw == apa_pkg::ST_ALLOC)
                                begin
                                    al = apa_pkg::cnt_inc(al);
                                end
                                avail_next = av;
                                alloc_next = al;
                                if (nw == apa_pkg::ST_ALLOC)
                                begin
                                    wentry_next = {nw, mac_reg, lbeg_reg, lid_reg};
                                end
                                else if (nw == apa_pkg::ST_AVAIL)
                                begin
                                    wentry_next = {nw, 48'd0, r_time, lid_reg};
                                end
                                else
                                begin
                                    wentry_next = {nw, r_mac, r_time, lid_reg};
                                end
                                state_next = apa_pkg::S_WRITE;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            apa_pkg::S_WRITE:
            begin
                we         = 1'b1;
                waddr      = wslot_reg;
                wdata      = wentry_reg;
                state_next = apa_pkg::S_DONE;
            end
            apa_pkg::S_DONE:
            begin
                if (!ov_reg)
                begin
                    ov_next    = 1'b1;
                    state_next = apa_pkg::S_IDLE;
                end
            end
            default: state_next = apa_pkg::S_IDLE;
        endcase
    end

    assign out_valid       = ov_reg;
    assign status          = status_reg;
    assign granted_address = grant_reg;
    assign free_count      = avail_reg;
    assign used_count      = alloc_reg;
endmodule
`default_nettype wire
